// ===== rtl/ack_range_tracker_assert.svh =====
// Assertion macros shared by the ack range tracker RTL.
`ifndef ACK_RANGE_TRACKER_ASSERT_SVH
`define ACK_RANGE_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ACKRT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ack_range_tracker: assertion failed");
`define ACKRT_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ack_range_tracker: sequence assertion failed");
`else
`define ACKRT_ASSERT(name, prop)
`define ACKRT_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ===== rtl/ackrt_pkg.sv =====
// Types, constants and codes of the ack range tracker.
package ackrt_pkg;

  localparam int MAX_RANGES = 32;
  localparam int MAX_OUT    = 32;
  localparam int PN_W       = 62;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ROT_W      = $clog2(MAX_RANGES);
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_RECEIVE, ACT_BUILD_ACK, ACT_TRIM, ACT_CLEAR
  } action_e;

  typedef enum logic [1:0] {
    KIND_STATUS, KIND_HEADER, KIND_RANGE, KIND_DONE
  } kind_e;

  typedef enum logic [2:0] {
    ST_DUPLICATE, ST_EXT_DOWN, ST_MERGED, ST_EXT_UP, ST_INSERTED, ST_INS_DROP
  } status_e;

  typedef enum logic [2:0] {
    CMD_NOP, CMD_COMPARE, CMD_RECEIVE, CMD_TRIM, CMD_CLEAR, CMD_ROTATE
  } cmd_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [PN_W-1:0] packet_number;
    logic            elicits_ack;
    logic [PN_W-1:0] delay_us;
  } in_t;

  typedef struct packed {
    logic [1:0]      item_kind;
    logic [2:0]      status;
    logic [PN_W-1:0] top_acked;
    logic [PN_W-1:0] delay_out;
    logic [PN_W-1:0] head_span;
    logic [PN_W-1:0] gap;
    logic [PN_W-1:0] range_length;
    logic            empty_res;
    logic            ack_pending;
    logic            last;
  } out_t;

  // classified transaction as queued between front and back
  typedef struct packed {
    action_e         act;
    logic [PN_W-1:0] pn;
    logic [PN_W:0]   pn_inc;
    logic [PN_W-1:0] pn_dec;
    logic            pn_nz;
    logic            elic;
    logic [PN_W-1:0] delay;
  } work_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [PN_W-1:0] pn;
    logic [PN_W:0]   pn_inc;
    logic [PN_W-1:0] pn_dec;
    logic            pn_nz;
  } store_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    status_e          status;
    logic [PN_W-1:0]  head_hi;
    logic [PN_W-1:0]  head_lo;
    logic [PN_W-1:0]  next_hi;
    logic [PN_W-1:0]  next_lo;
  } store_stat_t;

endpackage

// ===== rtl/ackrt_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
`include "ack_range_tracker_assert.svh"
module ackrt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ackrt_pkg::in_t in_data_i,
  output logic           q_valid_o,
  output ackrt_pkg::work_t q_item_o,
  input  logic           q_pop_i
);
  import ackrt_pkg::*;

  work_t             mem_q [FIFO_DEPTH];
  work_t             cls;
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              push, pop;

  always_comb begin
    cls.act    = action_e'(in_data_i.action);
    cls.pn     = in_data_i.packet_number;
    cls.pn_inc = {1'b0, in_data_i.packet_number} + {{PN_W{1'b0}}, 1'b1};
    cls.pn_dec = in_data_i.packet_number - {{(PN_W-1){1'b0}}, 1'b1};
    cls.pn_nz  = |in_data_i.packet_number;
    cls.elic   = in_data_i.elicits_ack;
    cls.delay  = in_data_i.delay_us;
  end

  assign in_stall_o = (fill_q == FILL_W'(FIFO_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill_q <= fill_q + FILL_W'(1);
        2'b01:   fill_q <= fill_q - FILL_W'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

  `ACKRT_ASSERT(a_fill_bound, fill_q <= FILL_W'(FIFO_DEPTH))
  `ACKRT_ASSERT(a_stall_full, in_stall_o |-> q_valid_o)
  `ACKRT_ASSERT_NEXT(a_push_seen, push, q_valid_o)

endmodule

// ===== rtl/ackrt_store.sv =====
// Range store: a chain of range cells with parallel compare and shift/merge.
`include "ack_range_tracker_assert.svh"
module ackrt_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ackrt_pkg::store_cmd_t  cmd_i,
  output ackrt_pkg::store_stat_t stat_o
);
  import ackrt_pkg::*;

  logic [PN_W-1:0]       hi_q [MAX_RANGES];
  logic [PN_W-1:0]       lo_q [MAX_RANGES];
  logic [PN_W-1:0]       hi_d [MAX_RANGES];
  logic [PN_W-1:0]       lo_d [MAX_RANGES];
  logic [PN_W-1:0]       hi_nx [MAX_RANGES];
  logic [PN_W-1:0]       lo_nx [MAX_RANGES];
  logic [PN_W-1:0]       hi_pv [MAX_RANGES];
  logic [PN_W-1:0]       lo_pv [MAX_RANGES];
  logic [CNT_W-1:0]      cnt_q, cnt_d, trim_cnt;
  logic [PN_W-1:0]       pn_q;
  logic [MAX_RANGES-1:0] valid;
  logic [MAX_RANGES-1:0] ge_d, lowle_d, lolt_d, loadj_d, hiadj_d;
  logic [MAX_RANGES-1:0] ge_q, lowle_q, lolt_q, loadj_q, hiadj_q;
  logic [MAX_RANGES-1:0] ge_sh_up, ge_sh_dn, last_ge, first_lt;
  logic [MAX_RANGES-1:0] fh, fh_dn, down_v, merge_v, ins_pos;
  logic                  dup;
  status_e               rcv_status;

  // neighbor views; the ring wrap serves rotation and only touches dead cells otherwise
  always_comb begin
    for (int k = 0; k < MAX_RANGES - 1; k++) begin
      hi_nx[k] = hi_q[k+1];
      lo_nx[k] = lo_q[k+1];
    end
    hi_nx[MAX_RANGES-1] = hi_q[0];
    lo_nx[MAX_RANGES-1] = lo_q[0];
    hi_pv[0] = hi_q[MAX_RANGES-1];
    lo_pv[0] = lo_q[MAX_RANGES-1];
    for (int k = 1; k < MAX_RANGES; k++) begin
      hi_pv[k] = hi_q[k-1];
      lo_pv[k] = lo_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_RANGES; k++) begin
      valid[k]   = (CNT_W'(k) < cnt_q);
      ge_d[k]    = valid[k] && (hi_q[k] >= cmd_i.pn);
      lowle_d[k] = (lo_q[k] <= cmd_i.pn);
      lolt_d[k]  = (lo_q[k] < cmd_i.pn);
      loadj_d[k] = ({1'b0, lo_q[k]} == cmd_i.pn_inc);
      hiadj_d[k] = cmd_i.pn_nz && (hi_q[k] == cmd_i.pn_dec);
    end
  end

  // ge_q is a thermometer: cells holding ranges at or above the number
  assign ge_sh_up = {ge_q[MAX_RANGES-2:0], 1'b1};
  assign ge_sh_dn = {1'b0, ge_q[MAX_RANGES-1:1]};
  assign last_ge  = ge_q & ~ge_sh_dn;
  assign first_lt = valid & ~ge_q & ge_sh_up;
  assign fh       = first_lt & hiadj_q;
  assign fh_dn    = {1'b0, fh[MAX_RANGES-1:1]};
  assign down_v   = last_ge & loadj_q;
  assign merge_v  = down_v & fh_dn;
  assign ins_pos  = ~ge_q & ge_sh_up;
  assign dup      = |(ge_q & lowle_q);

  always_comb begin
    if (dup) begin
      rcv_status = ST_DUPLICATE;
    end else if (|down_v) begin
      rcv_status = (|merge_v) ? ST_MERGED : ST_EXT_DOWN;
    end else if (|fh) begin
      rcv_status = ST_EXT_UP;
    end else if (cnt_q == CNT_W'(MAX_RANGES)) begin
      rcv_status = ST_INS_DROP;
    end else begin
      rcv_status = ST_INSERTED;
    end
  end

  always_comb begin
    trim_cnt = '0;
    for (int k = 0; k < MAX_RANGES; k++) begin
      if (last_ge[k]) trim_cnt = trim_cnt | CNT_W'(k + 1);
    end
  end

  always_comb begin
    hi_d  = hi_q;
    lo_d  = lo_q;
    cnt_d = cnt_q;
    case (cmd_i.cmd)
      CMD_RECEIVE: begin
        case (rcv_status)
          ST_EXT_DOWN: begin
            for (int k = 0; k < MAX_RANGES; k++) begin
              if (down_v[k]) lo_d[k] = pn_q;
            end
          end
          ST_MERGED: begin
            for (int k = 0; k < MAX_RANGES; k++) begin
              if (merge_v[k]) begin
                lo_d[k] = lo_nx[k];
              end else if (!ge_q[k]) begin
                hi_d[k] = hi_nx[k];
                lo_d[k] = lo_nx[k];
              end
            end
            cnt_d = cnt_q - CNT_W'(1);
          end
          ST_EXT_UP: begin
            for (int k = 0; k < MAX_RANGES; k++) begin
              if (fh[k]) hi_d[k] = pn_q;
            end
          end
          ST_INSERTED, ST_INS_DROP: begin
            for (int k = 0; k < MAX_RANGES; k++) begin
              if (ins_pos[k]) begin
                hi_d[k] = pn_q;
                lo_d[k] = pn_q;
              end else if (!ge_q[k]) begin
                hi_d[k] = hi_pv[k];
                lo_d[k] = lo_pv[k];
              end
            end
            if (rcv_status == ST_INSERTED) cnt_d = cnt_q + CNT_W'(1);
          end
          default: begin
          end
        endcase
      end
      CMD_TRIM: begin
        for (int k = 0; k < MAX_RANGES; k++) begin
          if (last_ge[k] && lolt_q[k]) lo_d[k] = pn_q;
        end
        cnt_d = trim_cnt;
      end
      CMD_CLEAR: cnt_d = '0;
      CMD_ROTATE: begin
        hi_d = hi_nx;
        lo_d = lo_nx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (cmd_i.cmd == CMD_COMPARE) pn_q <= cmd_i.pn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ge_q    <= '0;
      lowle_q <= '0;
      lolt_q  <= '0;
      loadj_q <= '0;
      hiadj_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.cmd == CMD_COMPARE) begin
        ge_q    <= ge_d;
        lowle_q <= lowle_d;
        lolt_q  <= lolt_d;
        loadj_q <= loadj_d;
        hiadj_q <= hiadj_d;
      end
    end
  end

  assign stat_o.cnt     = cnt_q;
  assign stat_o.status  = rcv_status;
  assign stat_o.head_hi = hi_q[0];
  assign stat_o.head_lo = lo_q[0];
  assign stat_o.next_hi = hi_q[1];
  assign stat_o.next_lo = lo_q[1];

  `ACKRT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_RANGES))
  `ACKRT_ASSERT(a_ge_thermo, (ge_q & ~ge_sh_up) == '0)
  `ACKRT_ASSERT(a_merge_two, (|merge_v) |-> (cnt_q >= CNT_W'(2)))

endmodule

// ===== rtl/ack_range_tracker.sv =====
// Top level: sequencer and output register of the ack range tracker.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (ackrt_pkg::in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (ackrt_pkg::out_t)
//
// Receive and trim run a parallel compare over all range cells, then one
// shift/merge/clip write; clear goes through the apply state as well.
// Build-ACK on an empty store or a single range emits only the header; otherwise
// the header, n range items one per cycle while the output is not stalled, then
// the ring rotates back home. A two-entry queue lets input keep arriving meanwhile.
// Reset clears counts and flags; range contents are undefined until written.
// Output stall holds the back end; the queue fills and then stalls input.
`include "ack_range_tracker_assert.svh"
module ack_range_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ackrt_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ackrt_pkg::out_t out_data_o
);
  import ackrt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_ITEM  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;

  logic [2:0]       state_q, state_d;
  work_t            work_q, work_d, q_item;
  logic             q_valid, q_pop;
  store_cmd_t       cmd;
  store_stat_t      st;
  logic [PN_W-1:0]  largest_q, largest_d;
  logic             lvalid_q, lvalid_d, needs_q, needs_d;
  logic [CNT_W-1:0] nitems_q, nitems_d, idx_q, idx_d, cnt_m1, n_calc;
  logic [ROT_W-1:0] rot_q, rot_d;
  logic             out_free, emit, out_valid_q;
  out_t             res, out_q;

  ackrt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  ackrt_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (st)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_m1   = st.cnt - CNT_W'(1);
  assign n_calc   = (int'(cnt_m1) > MAX_OUT - 1) ? CNT_W'(MAX_OUT - 1) : cnt_m1;

  always_comb begin
    state_d    = state_q;
    work_d     = work_q;
    largest_d  = largest_q;
    lvalid_d   = lvalid_q;
    needs_d    = needs_q;
    nitems_d   = nitems_q;
    idx_d      = idx_q;
    rot_d      = rot_q;
    q_pop      = 1'b0;
    emit       = 1'b0;
    res        = '0;
    cmd.cmd    = CMD_NOP;
    cmd.pn     = q_item.pn;
    cmd.pn_inc = q_item.pn_inc;
    cmd.pn_dec = q_item.pn_dec;
    cmd.pn_nz  = q_item.pn_nz;
    case (state_q)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          work_d = q_item;
          case (q_item.act)
            ACT_RECEIVE, ACT_TRIM: begin
              cmd.cmd = CMD_COMPARE;
              state_d = S_APPLY;
            end
            ACT_BUILD_ACK: state_d = S_HDR;
            ACT_CLEAR:     state_d = S_APPLY;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_APPLY: begin
        if (out_free) begin
          emit     = 1'b1;
          res.last = 1'b1;
          state_d  = S_IDLE;
          case (work_q.act)
            ACT_RECEIVE: begin
              cmd.cmd = CMD_RECEIVE;
              if (work_q.elic) needs_d = 1'b1;
              if (!lvalid_q || work_q.pn > largest_q) begin
                largest_d = work_q.pn;
                lvalid_d  = 1'b1;
              end
              res.item_kind = KIND_STATUS;
              res.status    = st.status;
            end
            ACT_TRIM: begin
              cmd.cmd       = CMD_TRIM;
              res.item_kind = KIND_DONE;
            end
            ACT_CLEAR: begin
              cmd.cmd       = CMD_CLEAR;
              largest_d     = '0;
              lvalid_d      = 1'b0;
              needs_d       = 1'b0;
              res.item_kind = KIND_DONE;
            end
            default: res.item_kind = KIND_DONE;
          endcase
        end
      end
      S_HDR: begin
        if (out_free) begin
          emit          = 1'b1;
          res.item_kind = KIND_HEADER;
          if (st.cnt == '0) begin
            res.empty_res = 1'b1;
            res.last      = 1'b1;
            state_d       = S_IDLE;
          end else begin
            needs_d       = 1'b0;
            res.top_acked = st.head_hi;
            res.delay_out = work_q.delay;
            res.head_span = st.head_hi - st.head_lo;
            res.last      = (n_calc == '0);
            nitems_d      = n_calc;
            idx_d         = CNT_W'(1);
            state_d       = (n_calc == '0) ? S_IDLE : S_ITEM;
          end
        end
      end
      S_ITEM: begin
        if (out_free) begin
          emit             = 1'b1;
          cmd.cmd          = CMD_ROTATE;
          res.item_kind    = KIND_RANGE;
          res.gap          = st.head_lo - st.next_hi - PN_W'(2);
          res.range_length = st.next_hi - st.next_lo;
          res.last         = (idx_q == nitems_q);
          rot_d            = rot_q + ROT_W'(1);
          idx_d            = idx_q + CNT_W'(1);
          if (idx_q == nitems_q) state_d = S_PAD;
        end
      end
      S_PAD: begin
        // finish the ring so range 0 is back in cell 0
        cmd.cmd = CMD_ROTATE;
        if (rot_q == ROT_W'(MAX_RANGES - 1)) begin
          rot_d   = '0;
          state_d = S_IDLE;
        end else begin
          rot_d = rot_q + ROT_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
    res.ack_pending = needs_d;
  end

  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    nitems_q <= nitems_d;
    idx_q    <= idx_d;
    if (emit) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      largest_q   <= '0;
      lvalid_q    <= 1'b0;
      needs_q     <= 1'b0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      largest_q <= largest_d;
      lvalid_q  <= lvalid_d;
      needs_q   <= needs_d;
      rot_q     <= rot_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ACKRT_ASSERT(a_rot_only_in_ack, (rot_q != '0) |-> (state_q == S_ITEM || state_q == S_PAD))
  `ACKRT_ASSERT_NEXT(a_pad_end, state_q == S_PAD && rot_q == ROT_W'(MAX_RANGES-1), state_q == S_IDLE)
  `ACKRT_ASSERT(a_emit_free, emit |-> out_free)

endmodule
